FILE: hw/rtl/bal_pkg.sv
// shared types and constants for the bounded array list
package bal_pkg;

    // word width of one list entry
    localparam int WORD_W = 32;

    // default number of entries
    localparam int DEF_CAPACITY = 16;

    // request codes
    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_READ   = 3'd1,
        REQ_WRITE  = 3'd2,
        REQ_SEARCH = 3'd3,
        REQ_REMOVE = 3'd4
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic              cap;   // compare phase: latch match flags
        logic              exe;   // execute phase: update entries
        t_req              op;
        logic [3:0]        idx;
        logic [WORD_W-1:0] word;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/bal_cell.sv
// one list entry: holds a word, matches it and shifts from its right neighbor
module bal_cell import bal_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [CW-1:0]     i_count,
    input  logic [WORD_W-1:0] i_next_word,
    input  logic              i_hit,
    output logic [WORD_W-1:0] o_word,
    output logic              o_hit,
    output logic              o_first
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic              r_match;
    logic              w_valid;
    logic              w_keep_next;
    logic              w_at_top;
    logic              w_addr;

    // position of this cell relative to the fill level
    assign w_valid     = {1'b0, i_count} > (CW+1)'(IDX);
    assign w_keep_next = {1'b0, i_count} > (CW+1)'(IDX + 1);
    assign w_at_top    = (i_count == CW'(IDX));
    assign w_addr      = (IDX < 16) && (int'(i_ctl.idx) == IDX);

    // first-match chain
    assign o_hit   = i_hit | r_match;
    assign o_first = r_match & ~i_hit;
    assign o_word  = r_word;

    // entry update
    always_comb begin
        n_word = r_word;
        if (i_ctl.exe) begin
            case (i_ctl.op)
                REQ_APPEND: begin
                    if (w_at_top) n_word = i_ctl.word;
                end
                REQ_WRITE: begin
                    if (w_addr) n_word = i_ctl.word;
                end
                REQ_REMOVE: begin
                    if (o_hit && w_keep_next) n_word = i_next_word;
                end
                default: n_word = r_word;
            endcase
        end
    end

    // entry and match registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word  <= '0;
            r_match <= 1'b0;
        end else begin
            r_word <= n_word;
            if (i_ctl.cap) r_match <= w_valid && (r_word == i_ctl.word);
        end
    end

endmodule

FILE: hw/rtl/bounded_array_list_top.sv
// bounded ordered list of signed words built as a chain of entry cells
//
// Input channel i_valid / o_ready carries one request item: i_req_type
// (append, read, overwrite, search, remove first match), i_slot_index and
// i_word_value. Output channel o_valid / i_ready carries one result item per
// request: status, read word, found position, entry total, full and empty.
// Each request runs in two phases: at the accept edge every cell compares its
// entry with the word and latches a match flag, and the read or old word is
// picked; in the execute cycle that follows, a ripple first-match chain through the
// cells picks the match, all cells update at once (append, overwrite or
// shift-down removal) and the result is loaded into the output register.
// o_valid rises when the result is loaded; no new request is taken during the
// execute cycle, so requests are handled one at a time.
// A result waiting in the output register blocks the next accept until the
// receiver takes it; the new request may be accepted at the same edge as
// the result.
// Synchronous active-low reset clears every entry to zero, the count to zero
// and drops both valid flags.
module bounded_array_list_top import bal_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_req_type,
    input  logic [3:0]        i_slot_index,
    input  logic signed [WORD_W-1:0] i_word_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic signed [WORD_W-1:0] o_read_word,
    output logic [4:0]        o_found_position,
    output logic [4:0]        o_entry_total,
    output logic              o_is_full,
    output logic              o_is_empty
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int NSLOT = (CAPACITY < 16) ? CAPACITY : 16;

    logic              r_busy;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    t_req              r_op;
    logic [3:0]        r_idx;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_rd;
    logic [WORD_W-1:0] w_rd_src;
    logic              r_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [WORD_W-1:0] r_read_word;
    logic [WORD_W-1:0] n_read_word;
    logic [CW-1:0]     w_pos;
    logic [4:0]        r_pos;
    logic [4:0]        n_pos;
    logic              w_accept;
    logic              w_any_hit;
    logic              w_idx_in_count;
    logic              w_idx_in_cap;
    logic              w_not_full;
    t_cell_ctl         w_ctl;

    logic [WORD_W-1:0] w_cell_word [CAPACITY];
    logic [CAPACITY:0] w_hit;
    logic [CAPACITY-1:0] w_first;

    // handshake
    assign w_accept = i_valid && o_ready;
    assign o_ready  = !r_busy && (!r_out_valid || i_ready);

    // control broadcast to the cells
    assign w_ctl.cap  = w_accept;
    assign w_ctl.exe  = r_busy;
    assign w_ctl.op   = r_op;
    assign w_ctl.idx  = r_idx;
    assign w_ctl.word = r_busy ? r_word : i_word_value;

    // cell chain
    assign w_hit[0] = 1'b0;
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [WORD_W-1:0] w_next;
        if (k < CAPACITY - 1) begin : g_mid
            assign w_next = w_cell_word[k+1];
        end else begin : g_end
            assign w_next = w_cell_word[k];
        end
        bal_cell #(
            .IDX (k),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_next_word (w_next),
            .i_hit       (w_hit[k]),
            .o_word      (w_cell_word[k]),
            .o_hit       (w_hit[k+1]),
            .o_first     (w_first[k])
        );
    end
    assign w_any_hit = w_hit[CAPACITY];

    // word at the requested slot, taken at accept
    always_comb begin
        w_rd_src = '0;
        for (int k = 0; k < NSLOT; k++) begin
            if (i_slot_index == 4'(k)) w_rd_src = w_cell_word[k];
        end
    end

    // one-hot first match to 1-based position
    always_comb begin
        w_pos = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_first[k]) w_pos = w_pos | CW'(k + 1);
        end
    end

    // range checks
    assign w_idx_in_count = (CW+4)'(r_idx) < (CW+4)'(r_count);
    assign w_idx_in_cap   = int'(r_idx) < CAPACITY;
    assign w_not_full     = r_count != CW'(CAPACITY);

    // result and next count
    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_read_word = '0;
        n_pos       = '0;
        case (r_op)
            REQ_APPEND: begin
                if (w_not_full) n_count = r_count + CW'(1);
                else n_status = ST_OVERFLOW;
            end
            REQ_READ: begin
                if (w_idx_in_count) n_read_word = r_rd;
                else n_status = ST_RANGE;
            end
            REQ_WRITE: begin
                if (w_idx_in_cap) n_read_word = r_rd;
                else n_status = ST_RANGE;
            end
            REQ_SEARCH: begin
                if (w_any_hit) n_pos = 5'(w_pos);
                else n_status = ST_NOTFOUND;
            end
            REQ_REMOVE: begin
                if (w_any_hit) n_count = r_count - CW'(1);
                else n_status = ST_NOTFOUND;
            end
            default: n_status = ST_OK;
        endcase
    end

    // request and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            if (w_accept) r_busy <= 1'b1;
            else if (r_busy) r_busy <= 1'b0;
            if (r_busy) r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= t_req'(i_req_type);
            r_idx  <= i_slot_index;
            r_word <= i_word_value;
            r_rd   <= w_rd_src;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_busy) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_status    <= n_status;
            r_read_word <= n_read_word;
            r_pos       <= n_pos;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_read_word      = r_read_word;
    assign o_found_position = r_pos;
    assign o_entry_total    = 5'(r_count);
    assign o_is_full        = (r_count == CW'(CAPACITY));
    assign o_is_empty       = (r_count == '0);

    // checks
    a_exec_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy && !o_ready)
        else $error("request not executed after accept");

    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> o_valid)
        else $error("no result after execute cycle");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} <= (CW+1)'(CAPACITY))
        else $error("entry count beyond capacity");

    a_single_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first match");

    a_count_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> $stable(r_count))
        else $error("count changed outside execute cycle");

endmodule

FILE: tb/tb_bounded_array_list_top.sv
// testbench for the bounded array list: scoreboard class, request and result drivers
`timescale 1ns / 100ps

import bal_pkg::*;

// one result item as the block reports it
typedef struct {
    logic [1:0]        status;
    logic [WORD_W-1:0] word;
    logic [4:0]        position;
    logic [4:0]        total;
    logic              full;
    logic              empty;
} t_list_result;

// mirrors the list contents and holds the results still owed by the block
class list_checker;
    logic [WORD_W-1:0] entries [DEF_CAPACITY];
    int unsigned       total;
    t_list_result      owed_results [$];
    int unsigned       errors;

    function new();
        foreach (entries[k]) entries[k] = '0;
        total  = 0;
        errors = 0;
    endfunction

    function int unsigned outstanding();
        return owed_results.size();
    endfunction

    // apply one accepted request to the mirror and queue its result
    function void note_request(logic [2:0] req, logic [3:0] slot, logic [WORD_W-1:0] word);
        t_list_result r;
        int           hit;
        int           k;
        r.status   = ST_OK;
        r.word     = '0;
        r.position = '0;
        hit        = -1;
        for (k = 0; k < int'(total); k++) begin
            if (hit < 0 && entries[k] == word) hit = k;
        end
        case (req)
            REQ_APPEND: begin
                if (total >= DEF_CAPACITY) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    entries[total] = word;
                    total++;
                end
            end
            REQ_READ: begin
                if (slot < total) r.word = entries[slot];
                else r.status = ST_RANGE;
            end
            REQ_WRITE: begin
                if (slot < DEF_CAPACITY) begin
                    r.word        = entries[slot];
                    entries[slot] = word;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            REQ_SEARCH: begin
                if (hit >= 0) r.position = 5'(hit + 1);
                else r.status = ST_NOTFOUND;
            end
            REQ_REMOVE: begin
                if (hit >= 0) begin
                    // compaction: later entries move down, top slot keeps its word
                    for (k = hit; k + 1 < int'(total); k++) entries[k] = entries[k + 1];
                    total--;
                end else begin
                    r.status = ST_NOTFOUND;
                end
            end
            default: ;
        endcase
        r.total = 5'(total);
        r.full  = (total == DEF_CAPACITY);
        r.empty = (total == 0);
        owed_results.push_back(r);
    endfunction

    // compare one accepted result with the oldest owed one
    function void check_result(t_list_result got);
        t_list_result exp;
        if (owed_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("result with nothing owed: status %0d word %0d pos %0d total %0d",
                         got.status, $signed(got.word), got.position, got.total);
            return;
        end
        exp = owed_results.pop_front();
        if (got.status !== exp.status || got.word !== exp.word
                || got.position !== exp.position || got.total !== exp.total
                || got.full !== exp.full || got.empty !== exp.empty) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch exp: status %0d word %0d pos %0d total %0d full %b empty %b",
                         exp.status, $signed(exp.word), exp.position, exp.total,
                         exp.full, exp.empty);
                $display("         got: status %0d word %0d pos %0d total %0d full %b empty %b",
                         got.status, $signed(got.word), got.position, got.total,
                         got.full, got.empty);
            end
        end
    endfunction
endclass

module tb_bounded_array_list_top import bal_pkg::*;;

    localparam int LIST_CAP       = DEF_CAPACITY;
    localparam int RANDOM_ITEMS   = 1330;
    localparam int STALL_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 8;

    // request codes the block treats as no operation
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_MID   = 3'd6;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} t_traffic_mode;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic                     o_ready;
    logic [2:0]               i_req_type   = '0;
    logic [3:0]               i_slot_index = '0;
    logic signed [WORD_W-1:0] i_word_value = '0;
    logic                     o_valid;
    logic                     i_ready      = 1'b0;
    logic [1:0]               o_status;
    logic signed [WORD_W-1:0] o_read_word;
    logic [4:0]               o_found_position;
    logic [4:0]               o_entry_total;
    logic                     o_is_full;
    logic                     o_is_empty;

    list_checker board = new();
    bit          calm  = 1'b0;
    int unsigned quiet_cycles = 0;

    bounded_array_list_top #(.CAPACITY(LIST_CAP)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_req_type       (i_req_type),
        .i_slot_index     (i_slot_index),
        .i_word_value     (i_word_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_read_word      (o_read_word),
        .o_found_position (o_found_position),
        .o_entry_total    (o_entry_total),
        .o_is_full        (o_is_full),
        .o_is_empty       (o_is_empty)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check accepted items, stall at random outside calm stretches
    always @(posedge i_clk) begin
        t_list_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.status   = o_status;
            got.word     = o_read_word;
            got.position = o_found_position;
            got.total    = o_entry_total;
            got.full     = o_is_full;
            got.empty    = o_is_empty;
            board.check_result(got);
        end
        i_ready <= calm || ($urandom_range(99) >= 18);
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d results owed", board.outstanding());
            $display("status: fail");
            $finish;
        end
    end

    // present one request item and hold it until accepted
    task automatic send_request(logic [2:0] req, logic [3:0] slot, logic [WORD_W-1:0] word);
        if (!calm && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_slot_index <= slot;
        i_word_value <= word;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(req, slot, word);
    endtask

    // hold off the sender until every owed result has arrived
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
    endtask

    // word values: corners and repeats so searches and removals hit
    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35) begin
            case ($urandom_range(7))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                3: return 32'h0000_0000;
                4: return 32'h0000_0001;
                default: return 32'($urandom_range(9));
            endcase
        end
        if (roll < 50 && board.total != 0)
            return board.entries[$urandom_range(board.total - 1)];
        return $urandom();
    endfunction

    // search and remove targets: mostly visible entries, some hidden slots above the count
    function automatic logic [WORD_W-1:0] pick_target();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55 && board.total != 0)
            return board.entries[$urandom_range(board.total - 1)];
        if (roll < 65)
            return board.entries[$urandom_range(LIST_CAP - 1)];
        return pick_word();
    endfunction

    function automatic logic [3:0] pick_slot();
        if ($urandom_range(99) < 70 && board.total != 0)
            return 4'($urandom_range(board.total - 1));
        return 4'($urandom_range(15));
    endfunction

    // one random request, op mix shaped by the traffic mode
    task automatic send_random(t_traffic_mode mode);
        int unsigned roll;
        int unsigned cut_app, cut_rd, cut_wr, cut_srch, cut_rm;
        roll = $urandom_range(99);
        case (mode)
            MODE_FILL:  begin cut_app = 55; cut_rd = 65; cut_wr = 75; cut_srch = 85; cut_rm = 95; end
            MODE_DRAIN: begin cut_app = 12; cut_rd = 27; cut_wr = 35; cut_srch = 50; cut_rm = 95; end
            default:    begin cut_app = 25; cut_rd = 43; cut_wr = 58; cut_srch = 73; cut_rm = 93; end
        endcase
        if (roll < cut_app)
            send_request(REQ_APPEND, 4'($urandom_range(15)), pick_word());
        else if (roll < cut_rd)
            send_request(REQ_READ, pick_slot(), $urandom());
        else if (roll < cut_wr)
            send_request(REQ_WRITE, pick_slot(), pick_word());
        else if (roll < cut_srch)
            send_request(REQ_SEARCH, 4'($urandom_range(15)), pick_target());
        else if (roll < cut_rm)
            send_request(REQ_REMOVE, 4'($urandom_range(15)), pick_target());
        else
            send_request(3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST)),
                         4'($urandom_range(15)), $urandom());
    endtask

    initial begin
        int unsigned   sent;
        int unsigned   seg_len;
        int unsigned   segment;
        t_traffic_mode mode;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corner words, every request, range and miss cases
        send_request(REQ_APPEND, 4'd0, 32'h8000_0000);
        send_request(REQ_APPEND, 4'd15, 32'h7fff_ffff);
        send_request(REQ_APPEND, 4'd0, 32'h0000_0000);
        send_request(REQ_APPEND, 4'd0, 32'hffff_ffff);
        send_request(REQ_APPEND, 4'd0, 32'h7fff_ffff);
        send_request(REQ_READ, 4'd0, 32'h0);
        send_request(REQ_READ, 4'd4, 32'h0);
        send_request(REQ_READ, 4'd5, 32'h0);
        send_request(REQ_READ, 4'd15, 32'hffff_ffff);
        // overwrite above the count writes a hidden slot
        send_request(REQ_WRITE, 4'd15, 32'h1234_5678);
        send_request(REQ_WRITE, 4'd1, 32'h5555_aaaa);
        send_request(REQ_SEARCH, 4'd0, 32'h7fff_ffff);
        send_request(REQ_SEARCH, 4'd0, 32'h1234_5678);
        send_request(REQ_SEARCH, 4'd0, 32'hffff_ffff);
        send_request(REQ_REMOVE, 4'd0, 32'h0000_0000);
        send_request(REQ_REMOVE, 4'd0, 32'h0bad_f00d);
        send_request(REQ_READ, 4'd3, 32'h0);
        send_request(REQ_SPARE_FIRST, 4'd15, 32'hffff_ffff);
        send_request(REQ_SPARE_MID, 4'd0, 32'h0);
        send_request(REQ_SPARE_LAST, 4'd9, 32'h8000_0001);
        // append reuses the slot vacated by the removal
        send_request(REQ_APPEND, 4'd0, 32'haaaa_5555);
        send_request(REQ_SEARCH, 4'd0, 32'h7fff_ffff);
        wait_drained();

        // random segments of fill, drain and mixed traffic
        sent    = 0;
        segment = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(30, 70);
            case ($urandom_range(2))
                0: mode = MODE_FILL;
                1: mode = MODE_DRAIN;
                default: mode = MODE_MIX;
            endcase
            calm = (segment >= 10 && segment < 14);
            repeat (seg_len) send_random(mode);
            sent += seg_len;
            segment++;
            if ($urandom_range(3) == 0) wait_drained();
        end
        calm = 1'b0;

        // wind down: all results in, then a short tail for strays
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bal_pkg.sv
hw/rtl/bal_cell.sv
hw/rtl/bounded_array_list_top.sv
tb/tb_bounded_array_list_top.sv
